// ----- rtl/core/mpps_pkg.sv -----
// ============================================================================
// mpps_pkg : shared constants for the masked pattern patch scanner
// Field widths of the patch result and the configuration register map.
// ============================================================================
`default_nettype none

package mpps_pkg;

	// Patch result: up to eight bytes, byte i at bits 8i+7..8i
	localparam int PATCH_BYTES = 8;
	localparam int PATCH_W     = 8 * PATCH_BYTES;

	// Pattern length register and internal length/fill counts
	localparam int PLEN_W = 4;

	// Configuration port
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;
	localparam int REG_IDX_W  = 3;

	// Register indexes (byte address = 8 * index)
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COMPARE_MASK      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REPLACE_MASK      = 3'd4;

	// Reset values of the registers
	localparam logic [PLEN_W-1:0]      RST_PATTERN_LENGTH = 4'd1;
	localparam logic [PATCH_BYTES-1:0] RST_COMPARE_MASK   = 8'hFF;

endpackage

`default_nettype wire

// ----- rtl/core/mpps_front.sv -----
// ============================================================================
// mpps_front : window capture and match detection
// Shift each accepted byte into the window until a match ends the scan,
// compare against the masked pattern and hand each hit to the queue.
// ============================================================================
`default_nettype none

module mpps_front #(
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int ADDRESS_BITS      = 48
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [mpps_pkg::PLEN_W-1:0]      pattern_length,
	input  wire logic [mpps_pkg::PATCH_W-1:0]     pattern_bytes,
	input  wire logic [mpps_pkg::PATCH_BYTES-1:0] compare_mask,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       data_byte,
	input  wire logic [ADDRESS_BITS-1:0]          byte_address,
	input  wire logic                             region_first,
	input  wire logic                             scan_start,
	input  wire logic                             queue_full,
	output logic                                  push,
	output logic [mpps_pkg::PATCH_W-1:0]          hit_window,
	output logic [ADDRESS_BITS-1:0]               hit_address,
	output logic [mpps_pkg::PLEN_W-1:0]           hit_len
);
	import mpps_pkg::*;

	localparam int WIN_W = 8 * MAX_PATTERN_BYTES;

	logic [WIN_W-1:0]       win_q;
	logic [WIN_W-1:0]       win_base;
	logic [WIN_W-1:0]       win_next;
	logic [WIN_W-1:0]       win_shift;
	logic [PATCH_W-1:0]     win_ext;
	logic [PATCH_W-1:0]     aligned;
	logic [PLEN_W-1:0]      fill_q;
	logic [PLEN_W-1:0]      fill_base;
	logic [PLEN_W-1:0]      fill_next;
	logic [PLEN_W-1:0]      len;
	logic [PLEN_W-1:0]      shift_bytes;
	logic [PATCH_BYTES-1:0] byte_en;
	logic [PATCH_BYTES-1:0] mism;
	logic                   found_q;
	logic                   found_eff;
	logic                   clr;
	logic                   accept;
	logic                   hit;

	// Clamp the configured length to 1..MAX_PATTERN_BYTES
	always_comb begin
		priority if (pattern_length == '0) begin
			len = PLEN_W'(1);
		end else if (pattern_length > PLEN_W'(MAX_PATTERN_BYTES)) begin
			len = PLEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len = pattern_length;
		end
	end

	assign in_ready  = ~queue_full;
	assign accept    = in_valid & in_ready;
	assign found_eff = found_q & ~scan_start;
	assign clr       = scan_start | region_first;

	assign win_base  = clr ? '0 : win_q;
	assign fill_base = clr ? '0 : fill_q;
	assign win_next  = (win_base >> 8) | (WIN_W'(data_byte) << (8 * (MAX_PATTERN_BYTES - 1)));
	assign fill_next = (fill_base < PLEN_W'(MAX_PATTERN_BYTES)) ? fill_base + PLEN_W'(1)
	                                                          : fill_base;

	// Bring the newest len bytes down to byte 0
	assign shift_bytes = PLEN_W'(MAX_PATTERN_BYTES) - len;
	assign win_shift   = win_next >> {shift_bytes, 3'b000};
	assign win_ext     = PATCH_W'(win_shift);

	always_comb begin
		for (int i = 0; i < PATCH_BYTES; i++) begin
			byte_en[i]       = PLEN_W'(i) < len;
			aligned[8*i +: 8] = byte_en[i] ? win_ext[8*i +: 8] : 8'h00;
			mism[i]          = byte_en[i] & compare_mask[i] &
			                   (aligned[8*i +: 8] != pattern_bytes[8*i +: 8]);
		end
	end

	assign hit  = ~found_eff & (fill_next >= len) & ~|mism;
	assign push = accept & hit;

	assign hit_window  = aligned;
	assign hit_address = byte_address;
	assign hit_len     = len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			fill_q  <= '0;
		end else if (accept) begin
			found_q <= found_eff | hit;
			if (!found_eff) begin
				fill_q <= fill_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !found_eff) begin
			win_q <= win_next;
		end
	end

	a_drop_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && found_q && !scan_start) |-> !push)
		else $error("hit pushed after a match in the same scan");

	a_match_latched: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> found_q)
		else $error("found flag not set after a hit");

endmodule

`default_nettype wire

// ----- rtl/core/mpps_queue.sv -----
// ============================================================================
// mpps_queue : short hit queue
// Register-based FIFO between the match front and the patch back end.
// ============================================================================
`default_nettype none

module mpps_queue #(
	parameter int WIDTH = 120,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("hit queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("hit queue underflow");

endmodule

`default_nettype wire

// ----- rtl/core/mpps_back.sv -----
// ============================================================================
// mpps_back : patch builder and result register
// Merge replacement bytes, form the start address and hold the result word.
// ============================================================================
`default_nettype none

module mpps_back #(
	parameter int ADDRESS_BITS = 48
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [mpps_pkg::PATCH_W-1:0]     replacement_bytes,
	input  wire logic [mpps_pkg::PATCH_BYTES-1:0] replace_mask,
	input  wire logic                             q_empty,
	output logic                                  q_pop,
	input  wire logic [mpps_pkg::PATCH_W-1:0]     hit_window,
	input  wire logic [ADDRESS_BITS-1:0]          hit_address,
	input  wire logic [mpps_pkg::PLEN_W-1:0]      hit_len,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [ADDRESS_BITS-1:0]               match_address,
	output logic [mpps_pkg::PATCH_W-1:0]          patched_window,
	output logic [mpps_pkg::PATCH_BYTES-1:0]      write_mask
);
	import mpps_pkg::*;

	logic [PATCH_BYTES-1:0]  byte_en;
	logic [PATCH_BYTES-1:0]  sel;
	logic [PATCH_W-1:0]      patched;
	logic [ADDRESS_BITS-1:0] start_addr;
	logic                    out_valid_q;
	logic [ADDRESS_BITS-1:0] match_address_q;
	logic [PATCH_W-1:0]      patched_window_q;
	logic [PATCH_BYTES-1:0]  write_mask_q;

	always_comb begin
		for (int i = 0; i < PATCH_BYTES; i++) begin
			byte_en[i]        = PLEN_W'(i) < hit_len;
			sel[i]            = byte_en[i] & replace_mask[i];
			patched[8*i +: 8] = sel[i] ? replacement_bytes[8*i +: 8] : hit_window[8*i +: 8];
		end
	end

	// Length is at least one, so len-1 never wraps
	assign start_addr = hit_address - ADDRESS_BITS'(hit_len - PLEN_W'(1));
	assign q_pop      = ~q_empty & (~out_valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			match_address_q  <= start_addr;
			patched_window_q <= patched;
			write_mask_q     <= sel;
		end
	end

	assign out_valid      = out_valid_q;
	assign match_address  = match_address_q;
	assign patched_window = patched_window_q;
	assign write_mask     = write_mask_q;

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid_q)
		else $error("result register not loaded after pop");

endmodule

`default_nettype wire

// ----- rtl/core/masked_pattern_patch_scanner_core.sv -----
// ============================================================================
// masked_pattern_patch_scanner_core : wildcard byte signature scan with patch
// Scan a byte stream for a masked pattern and report the first match per scan.
// ============================================================================
// Usage
//   s_axis: one memory byte per word. tdata = {byte_address, data_byte};
//   tuser = {scan_start, region_first}. region_first empties the window,
//   scan_start also re-arms the search after a match.
//   m_axis: one word per match. tdata = {write_mask, patched_window,
//   match_address}, zero padded to whole bytes.
//   APB: five registers at byte addresses 0, 8, 16, 24, 32; writes land in
//   the access phase, reads return the register. Write only while idle.
// Throughput: one input word per cycle while the hit queue is not full, set
//   by the window shift and parallel compare in the front end.
// Path: the accepting edge of a matching byte writes the hit queue; the
//   result register loads from the queue once that register is free or its
//   word is being taken, and m_axis_tvalid is driven from the result register.
// Reset: window empty, no match pending, registers at their defaults
//   (length 1, compare mask all ones, others zero).
// Stall: if m_axis_tready is held low, one hit waits in the result register
//   and up to two more in the hit queue; s_axis_tready drops only while that
//   queue is full.
// ============================================================================
`default_nettype none

module masked_pattern_patch_scanner_core #(
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int ADDRESS_BITS      = 48
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// APB register port
	input  wire logic                                    psel,
	input  wire logic                                    penable,
	input  wire logic                                    pwrite,
	input  wire logic [mpps_pkg::CFG_ADDR_W-1:0]         paddr,
	input  wire logic [mpps_pkg::CFG_DATA_W-1:0]         pwdata,
	output logic [mpps_pkg::CFG_DATA_W-1:0]              prdata,
	output logic                                         pready,
	// input byte stream
	input  wire logic                                    s_axis_tvalid,
	output logic                                         s_axis_tready,
	// tdata: data_byte [7:0], byte_address [8+ADDRESS_BITS-1:8], zero pad
	input  wire logic [((ADDRESS_BITS+15)/8)*8-1:0]      s_axis_tdata,
	// tuser: region_first [0], scan_start [1]
	input  wire logic [1:0]                              s_axis_tuser,
	// match result stream
	output logic                                         m_axis_tvalid,
	input  wire logic                                    m_axis_tready,
	// tdata: match_address, patched_window (64), write_mask (8), zero pad
	output logic [((ADDRESS_BITS+79)/8)*8-1:0]           m_axis_tdata
);
	import mpps_pkg::*;

	localparam int OUT_W = ((ADDRESS_BITS + 79) / 8) * 8;
	localparam int Q_W   = PATCH_W + ADDRESS_BITS + PLEN_W;

	// configuration registers
	logic [PLEN_W-1:0]      pattern_length_q;
	logic [PATCH_W-1:0]     pattern_bytes_q;
	logic [PATCH_BYTES-1:0] compare_mask_q;
	logic [PATCH_W-1:0]     replacement_bytes_q;
	logic [PATCH_BYTES-1:0] replace_mask_q;
	logic                   cfg_wr;
	logic [REG_IDX_W-1:0]   cfg_idx;

	// front to queue
	logic                    push;
	logic [PATCH_W-1:0]      f_window;
	logic [ADDRESS_BITS-1:0] f_address;
	logic [PLEN_W-1:0]       f_len;
	logic                    q_full;
	// queue to back
	logic                    q_pop;
	logic                    q_empty;
	logic [Q_W-1:0]          q_rd;
	// result
	logic [ADDRESS_BITS-1:0] match_address;
	logic [PATCH_W-1:0]      patched_window;
	logic [PATCH_BYTES-1:0]  write_mask;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[CFG_ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q    <= RST_PATTERN_LENGTH;
			pattern_bytes_q     <= '0;
			compare_mask_q      <= RST_COMPARE_MASK;
			replacement_bytes_q <= '0;
			replace_mask_q      <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PATTERN_LENGTH:    pattern_length_q    <= pwdata[PLEN_W-1:0];
				REG_PATTERN_BYTES:     pattern_bytes_q     <= pwdata;
				REG_COMPARE_MASK:      compare_mask_q      <= pwdata[PATCH_BYTES-1:0];
				REG_REPLACEMENT_BYTES: replacement_bytes_q <= pwdata;
				REG_REPLACE_MASK:      replace_mask_q      <= pwdata[PATCH_BYTES-1:0];
				default: ;  // drop writes beyond the map
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PATTERN_LENGTH:    prdata = CFG_DATA_W'(pattern_length_q);
			REG_PATTERN_BYTES:     prdata = pattern_bytes_q;
			REG_COMPARE_MASK:      prdata = CFG_DATA_W'(compare_mask_q);
			REG_REPLACEMENT_BYTES: prdata = replacement_bytes_q;
			REG_REPLACE_MASK:      prdata = CFG_DATA_W'(replace_mask_q);
			default:               prdata = '0;
		endcase
	end

	// ---------------------------------------------------------- front end
	mpps_front #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
		.ADDRESS_BITS      (ADDRESS_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.pattern_length (pattern_length_q),
		.pattern_bytes  (pattern_bytes_q),
		.compare_mask   (compare_mask_q),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.data_byte      (s_axis_tdata[7:0]),
		.byte_address   (s_axis_tdata[8 +: ADDRESS_BITS]),
		.region_first   (s_axis_tuser[0]),
		.scan_start     (s_axis_tuser[1]),
		.queue_full     (q_full),
		.push           (push),
		.hit_window     (f_window),
		.hit_address    (f_address),
		.hit_len        (f_len)
	);

	// ---------------------------------------------------------- hit queue
	mpps_queue #(
		.WIDTH (Q_W),
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_len, f_address, f_window}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rd),
		.empty     (q_empty)
	);

	// ----------------------------------------------------------- back end
	mpps_back #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.replacement_bytes (replacement_bytes_q),
		.replace_mask      (replace_mask_q),
		.q_empty           (q_empty),
		.q_pop             (q_pop),
		.hit_window        (q_rd[PATCH_W-1:0]),
		.hit_address       (q_rd[PATCH_W +: ADDRESS_BITS]),
		.hit_len           (q_rd[PATCH_W + ADDRESS_BITS +: PLEN_W]),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.match_address     (match_address),
		.patched_window    (patched_window),
		.write_mask        (write_mask)
	);

	// pack the result word, low field first, zero pad on top
	assign m_axis_tdata = OUT_W'({write_mask, patched_window, match_address});

endmodule

`default_nettype wire

// ----- tb/sv/tb_masked_pattern_patch_scanner_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_masked_pattern_patch_scanner_core : self-checking scanner regression
// Drive byte words with addresses and region/scan flags into the scanner,
// predict each patch result in a behavioural model of the window compare and
// merge, and check every result word field by field. Covers register
// extremes, wildcard masks, address wrap, back-pressure and random idling.
// ============================================================================

module tb_masked_pattern_patch_scanner_core;
	import mpps_pkg::*;

	localparam int ADDR_W      = 48;
	localparam int WIN_BYTES   = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SCAN_TARGET = 800;
	localparam int NUM_PHASES  = 8;
	localparam int HOLD_CYCLES = 400;

	// one expected patch result
	typedef struct packed {
		logic [ADDR_W-1:0] match_address;
		logic [63:0]       patched_window;
		logic [7:0]        write_mask;
	} patch_t;

	// one row of the directed script: a register write or a byte word
	typedef struct packed {
		bit                   is_cfg;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [63:0]          reg_value;
		logic [7:0]           data_byte;
		logic [ADDR_W-1:0]    byte_address;
		bit                   region_first;
		bit                   scan_start;
		bit                   known;       // expected result typed in below
		bit                   known_hit;
		patch_t               known_patch;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata = '0;   // data_byte [7:0], byte_address [55:8]
	logic [1:0]   s_axis_tuser = '0;   // region_first [0], scan_start [1]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// match_address [47:0], patched_window [111:48], write_mask [119:112]
	logic [119:0] m_axis_tdata;

	masked_pattern_patch_scanner_core #(
		.MAX_PATTERN_BYTES(WIN_BYTES),
		.ADDRESS_BITS(ADDR_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Scanner model: register copies and window state
	// ------------------------------------------------------------------------
	logic [PLEN_W-1:0] len_reg = RST_PATTERN_LENGTH;
	logic [63:0]       pattern_reg = '0;
	logic [7:0]        compare_reg = RST_COMPARE_MASK;
	logic [63:0]       replacement_reg = '0;
	logic [7:0]        replace_reg = '0;

	logic [7:0]  window_q [WIN_BYTES];
	int unsigned window_fill = 0;
	bit          scan_done = 1'b0;

	patch_t pending_patches [$];

	int unsigned fail_count = 0;
	int unsigned patches_seen = 0;
	int unsigned words_scanned = 0;
	int unsigned settings_used = 0;
	int unsigned cycle_count = 0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// long receiver hold-off, requested by the stimulus and counted below
	bit          hold_go = 1'b0;
	bit          hold_seen = 1'b0;
	int unsigned hold_left = 0;

	initial begin
		foreach (window_q[i])
			window_q[i] = 8'h00;
	end

	function automatic int unsigned active_length();
		if (len_reg == 0)
			return 1;
		if (len_reg > WIN_BYTES)
			return WIN_BYTES;
		return len_reg;
	endfunction

	task automatic empty_window();
		foreach (window_q[i])
			window_q[i] = 8'h00;
		window_fill = 0;
	endtask

	// advance the window by one byte and work out the patch it causes, if any
	task automatic scan_model(input logic [7:0] d, input logic [ADDR_W-1:0] a,
			input bit rf, input bit ss, output bit hit, output patch_t p);
		int unsigned n;
		int unsigned base;
		logic [63:0] merged;
		hit = 1'b0;
		p = '0;
		merged = '0;
		if (ss) begin
			scan_done = 1'b0;
			empty_window();
		end
		if (scan_done)
			return;
		if (rf)
			empty_window();
		for (int i = 0; i < WIN_BYTES - 1; i++)
			window_q[i] = window_q[i + 1];
		window_q[WIN_BYTES - 1] = d;
		if (window_fill < WIN_BYTES)
			window_fill++;
		n = active_length();
		if (window_fill < n)
			return;
		base = WIN_BYTES - n;
		// wildcard bytes skip the compare
		for (int i = 0; i < n; i++)
			if (compare_reg[i] && window_q[base + i] != pattern_reg[8*i +: 8])
				return;
		for (int i = 0; i < n; i++)
			merged[8*i +: 8] = replace_reg[i] ? replacement_reg[8*i +: 8] : window_q[base + i];
		p.match_address = a - ADDR_W'(n - 1);
		p.patched_window = merged;
		p.write_mask = replace_reg & 8'((1 << n) - 1);
		hit = 1'b1;
		scan_done = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Register port
	// ------------------------------------------------------------------------
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// keep the model's copy at the register widths
		case (idx)
			REG_PATTERN_LENGTH:    len_reg = value[PLEN_W-1:0];
			REG_PATTERN_BYTES:     pattern_reg = value;
			REG_COMPARE_MASK:      compare_reg = value[7:0];
			REG_REPLACEMENT_BYTES: replacement_reg = value;
			REG_REPLACE_MASK:      replace_reg = value[7:0];
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Byte stream sender
	// ------------------------------------------------------------------------
	task automatic send_word(input logic [7:0] d, input logic [ADDR_W-1:0] a,
			input bit rf, input bit ss, output bit hit, output patch_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {a, d};
		s_axis_tuser <= {ss, rf};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		scan_model(d, a, rf, ss, hit, p);
		words_scanned++;
	endtask

	task automatic scan_word(input logic [7:0] d, input logic [ADDR_W-1:0] a,
			input bit rf, input bit ss);
		bit hit;
		patch_t p;
		send_word(d, a, rf, ss, hit, p);
		if (hit)
			pending_patches = {pending_patches, p};
	endtask

	// drop valid, wait for every patch, then let the pipe settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_patches.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic script_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
			input logic [63:0] value);
		script_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_value = value;
		return r;
	endfunction

	function automatic script_row_t word_row(input logic [7:0] d,
			input logic [ADDR_W-1:0] a, input bit rf, input bit ss);
		script_row_t r;
		r = '0;
		r.data_byte = d;
		r.byte_address = a;
		r.region_first = rf;
		r.scan_start = ss;
		return r;
	endfunction

	function automatic script_row_t known_row(input logic [7:0] d,
			input logic [ADDR_W-1:0] a, input bit rf, input bit ss, input bit hit,
			input patch_t p);
		script_row_t r;
		r = word_row(d, a, rf, ss);
		r.known = 1'b1;
		r.known_hit = hit;
		r.known_patch = p;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Result checker: compare each patch word with the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		patch_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			patches_seen++;
			if (pending_patches.size() == 0) begin
				$error("unexpected patch word: match_address %h", m_axis_tdata[47:0]);
				fail_count++;
			end else begin
				want = pending_patches.pop_front();
				if (m_axis_tdata[47:0] !== want.match_address) begin
					$error("match_address: expected %h, got %h",
						want.match_address, m_axis_tdata[47:0]);
					fail_count++;
				end
				if (m_axis_tdata[111:48] !== want.patched_window) begin
					$error("patched_window: expected %h, got %h",
						want.patched_window, m_axis_tdata[111:48]);
					fail_count++;
				end
				if (m_axis_tdata[119:112] !== want.write_mask) begin
					$error("write_mask: expected %h, got %h",
						want.write_mask, m_axis_tdata[119:112]);
					fail_count++;
				end
			end
		end
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("masked_pattern_patch_scanner_core regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		script_row_t script [$];
		script_row_t row;
		bit hit;
		patch_t p;
		logic [ADDR_W-1:0] addr;
		int unsigned n;
		int unsigned phase;
		int unsigned waited;
		int unsigned phase_goal;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: length 1, pattern zero, exact compare, no replace
		script = {script, known_row(8'h00, 48'h0000_0000_1000, 1'b0, 1'b1, 1'b1,
			'{48'h0000_0000_1000, 64'h0, 8'h00})};
		// after the match, words without scan_start are ignored
		script = {script, known_row(8'h00, 48'h0000_0000_1001, 1'b0, 1'b0, 1'b0, '0)};
		script = {script, known_row(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, '0)};
		script = {script, known_row(8'h00, 48'h0000_0000_0000, 1'b0, 1'b0, 1'b1,
			'{48'h0000_0000_0000, 64'h0, 8'h00})};
		// full eight-byte pattern, every byte replaced
		script = {script, cfg_row(REG_PATTERN_LENGTH, 64'd8)};
		script = {script, cfg_row(REG_PATTERN_BYTES, 64'h8877_6655_4433_2211)};
		script = {script, cfg_row(REG_REPLACEMENT_BYTES, 64'hA5C3_0FF0_5AE1_7E96)};
		script = {script, cfg_row(REG_REPLACE_MASK, 64'hFF)};
		for (int i = 0; i < 8; i++)
			script = {script, word_row(8'(8'h11 * (i + 1)), 48'(i), i == 0, i == 0)};
		script = {script, word_row(8'h00, 48'h0000_0000_0008, 1'b0, 1'b0)};
		// window spanning the top of the address space
		for (int i = 0; i < 8; i++)
			script = {script, word_row(8'(8'h11 * (i + 1)), 48'hFFFF_FFFF_FFFA + 48'(i),
				i == 0, i == 0)};
		// length zero is taken as one; all wildcards; upper write bits dropped
		script = {script, cfg_row(REG_PATTERN_LENGTH, 64'd0)};
		script = {script, cfg_row(REG_COMPARE_MASK, 64'h0)};
		script = {script, cfg_row(REG_REPLACE_MASK, 64'hFFFF_FFFF_FFFF_FF01)};
		script = {script, word_row(8'h5A, 48'h1234_5678_9ABC, 1'b0, 1'b1)};
		// length above eight is clamped; partial window gives nothing
		script = {script, cfg_row(REG_PATTERN_LENGTH, 64'hF)};
		script = {script, cfg_row(REG_COMPARE_MASK, 64'h01)};
		script = {script, word_row(8'h11, 48'h0000_0000_0100, 1'b0, 1'b1)};
		script = {script, word_row(8'hFF, 48'h0000_0000_0200, 1'b1, 1'b0)};

		foreach (script[k]) begin
			row = script[k];
			if (row.is_cfg) begin
				drain();
				apb_write(row.reg_idx, row.reg_value);
			end else begin
				send_word(row.data_byte, row.byte_address, row.region_first,
					row.scan_start, hit, p);
				if (row.known) begin
					if (row.known_hit)
						pending_patches = {pending_patches, row.known_patch};
				end else if (hit)
					pending_patches = {pending_patches, p};
			end
		end
		drain();
		settings_used = 4;

		// random phases: new settings, then well-formed scans with random content
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			case (phase)
				0: apb_write(REG_PATTERN_LENGTH, 64'd1);
				1: apb_write(REG_PATTERN_LENGTH, 64'd8);
				2: apb_write(REG_PATTERN_LENGTH, {$urandom, $urandom} & ~64'hF);
				3: apb_write(REG_PATTERN_LENGTH, {$urandom, $urandom} | 64'hF);
				default: apb_write(REG_PATTERN_LENGTH,
					{$urandom, 28'($urandom), 4'($urandom_range(0, 15))});
			endcase
			apb_write(REG_PATTERN_BYTES, {$urandom, $urandom});
			apb_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
			case (phase)
				1: begin
					apb_write(REG_COMPARE_MASK, 64'hFF);
					apb_write(REG_REPLACE_MASK, 64'hFF);
				end
				5: begin
					apb_write(REG_COMPARE_MASK, 64'h00);
					apb_write(REG_REPLACE_MASK, 64'h00);
				end
				default: begin
					apb_write(REG_COMPARE_MASK, {$urandom, $urandom});
					apb_write(REG_REPLACE_MASK, {$urandom, $urandom});
				end
			endcase
			settings_used++;
			@(posedge clk);

			phase_goal = words_scanned + SCAN_TARGET / NUM_PHASES;
			while (words_scanned < phase_goal) begin
				n = active_length();
				addr = ($urandom_range(0, 9) == 0) ? 48'hFFFF_FFFF_FFF8 + 48'($urandom_range(0, 7))
					: {16'($urandom), $urandom};
				// open a scan
				scan_word(8'($urandom), addr, $urandom_range(0, 1), 1'b1);
				addr++;
				// random lead-in, with the odd region break or stray restart
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 11) == 0) begin
						addr = {16'($urandom), $urandom};
						scan_word(8'($urandom), addr, 1'b1, $urandom_range(0, 29) == 0);
					end else
						scan_word(8'($urandom), addr, 1'b0, $urandom_range(0, 29) == 0);
					addr++;
				end
				// plant the pattern, wildcards random, sometimes with one byte spoilt
				if ($urandom_range(0, 99) < 75) begin
					int unsigned spoil;
					spoil = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : WIN_BYTES;
					for (int i = 0; i < n; i++) begin
						logic [7:0] b;
						b = compare_reg[i] ? pattern_reg[8*i +: 8] : 8'($urandom);
						if (i == spoil)
							b = b ^ 8'($urandom_range(1, 255));
						scan_word(b, addr, 1'b0, 1'b0);
						addr++;
					end
				end
				repeat ($urandom_range(0, 3)) begin
					scan_word(8'($urandom), addr, 1'b0, 1'b0);
					addr++;
				end
			end
			drain();
		end

		// back-pressure: every word matches while the receiver holds off
		send_idle_pct = 0;
		recv_stall_pct = 0;
		apb_write(REG_PATTERN_LENGTH, 64'd1);
		apb_write(REG_COMPARE_MASK, 64'h00);
		apb_write(REG_REPLACE_MASK, {$urandom, $urandom});
		settings_used++;
		@(posedge clk);
		hold_go = ~hold_go;
		repeat (40)
			scan_word(8'($urandom), {16'($urandom), $urandom}, $urandom_range(0, 1), 1'b1);

		// wait out every expected patch, then the pipeline latency
		s_axis_tvalid <= 1'b0;
		for (waited = 0; waited < 4 * HOLD_CYCLES && pending_patches.size() != 0; waited++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_patches.size() != 0) begin
			$error("%0d patch words never arrived", pending_patches.size());
			fail_count++;
		end

		$display("Scanned %0d words across %0d register settings; %0d patch words checked,",
			words_scanned, settings_used, patches_seen);
		$display("including a %0d-cycle receiver hold-off with the input stalled.", HOLD_CYCLES);
		if (fail_count == 0)
			$display("masked_pattern_patch_scanner_core regression: pass");
		else
			$display("masked_pattern_patch_scanner_core regression: fail");
		$finish;
	end

endmodule
